// File: hdl/ahfp_pkg.sv
// Shared types, constants and the hex digit decode for the ASCII-hex frame parser.
package ahfp_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int SUM_SPAN    = 14;
    localparam int CHK_HI_POS  = 14;
    localparam int CHK_LO_POS  = 15;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [7:0] START_BYTE_RST = 8'h5B;
    localparam logic [7:0] END_BYTE_RST   = 8'h5D;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;
    localparam logic [7:0] ALPHA_GAP      = 8'd7;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;

    // register indexes (paddr[2])
    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_END_BYTE   = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CHK_ERR = 1'b1;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } t_cfg;

    typedef struct packed {
        logic        frame_status;
        logic [7:0]  frame_length;
        logic [15:0] command_word;
        logic [7:0]  data_byte_0;
        logic [7:0]  data_byte_1;
        logic [7:0]  data_byte_2;
        logic [7:0]  data_byte_3;
    } t_result;

    typedef logic [7:0] t_store [STORE_DEPTH];

    // subtract '0', then close the gap up to 'A' when above nine
    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] r;
        r = c - ASCII_ZERO;
        if (r > 8'd9) begin
            r = r - ALPHA_GAP;
        end
        return r;
    endfunction

endpackage

// File: hdl/ahfp_apb_regs.sv
// APB register file holding the start and end delimiter bytes.
module ahfp_apb_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output ahfp_pkg::t_cfg  o_cfg
);

    logic [7:0] r_start_byte;
    logic [7:0] r_end_byte;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= ahfp_pkg::START_BYTE_RST;
            r_end_byte   <= ahfp_pkg::END_BYTE_RST;
        end else if (w_wr) begin
            if (paddr[2] == ahfp_pkg::REG_START_BYTE) begin
                r_start_byte <= pwdata[7:0];
            end else begin
                r_end_byte <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ahfp_pkg::REG_START_BYTE) begin
            prdata = {24'h0, r_start_byte};
        end else begin
            prdata = {24'h0, r_end_byte};
        end
    end

    // low address bits are unused; decode ignores them
    logic [1:0] w_unused_addr;
    assign w_unused_addr = paddr[1:0];

    assign o_cfg.start_byte = r_start_byte;
    assign o_cfg.end_byte   = r_end_byte;

endmodule

// File: hdl/ahfp_frame_core.sv
// Frame state, payload store, checksum check and result build for one beat.
module ahfp_frame_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ahfp_pkg::t_cfg    i_cfg,
    input  logic              i_beat,
    input  logic [7:0]        i_rx_byte,
    output logic              o_res_fire,
    output ahfp_pkg::t_result o_result
);

    logic                r_in_frame;
    logic [7:0]          r_byte_count;
    logic [7:0]          r_running_sum;
    ahfp_pkg::t_store    r_store;

    logic                n_in_frame;
    logic [7:0]          n_byte_count;
    logic [7:0]          n_running_sum;
    ahfp_pkg::t_store    n_store;

    ahfp_pkg::t_store    w_dec;
    logic [7:0]          w_rx_chk;
    logic                w_match;
    logic [7:0]          w_count_inc;
    logic                w_is_end;

    always_comb begin
        for (int i = 0; i < ahfp_pkg::STORE_DEPTH; i++) begin
            w_dec[i] = ahfp_pkg::hex_digit(r_store[i]);
        end
    end

    assign w_rx_chk    = {w_dec[ahfp_pkg::CHK_HI_POS][3:0], 4'h0} | w_dec[ahfp_pkg::CHK_LO_POS];
    assign w_match     = (w_rx_chk == r_running_sum);
    assign w_count_inc = (r_byte_count == ahfp_pkg::COUNT_MAX) ? r_byte_count
                                                               : r_byte_count + 8'd1;
    assign w_is_end    = (i_rx_byte == i_cfg.end_byte);
    assign o_res_fire  = i_beat && r_in_frame && w_is_end;

    // next state
    always_comb begin
        n_in_frame    = r_in_frame;
        n_byte_count  = r_byte_count;
        n_running_sum = r_running_sum;
        n_store       = r_store;
        if (i_beat) begin
            if (!r_in_frame) begin
                if (i_rx_byte == i_cfg.start_byte) begin
                    n_in_frame    = 1'b1;
                    n_byte_count  = 8'd0;
                    n_running_sum = 8'd0;
                end
            end else if (w_is_end) begin
                n_in_frame    = 1'b0;
                n_byte_count  = 8'd0;
                n_running_sum = 8'd0;
                if (w_match) begin
                    n_store = w_dec;
                end
            end else begin
                n_byte_count = w_count_inc;
                if (r_byte_count < 8'(ahfp_pkg::STORE_DEPTH)) begin
                    n_store[r_byte_count[ahfp_pkg::IDX_W-1:0]] = i_rx_byte;
                end
                if (r_byte_count < 8'(ahfp_pkg::SUM_SPAN)) begin
                    n_running_sum = r_running_sum + i_rx_byte;
                end
            end
        end
    end

    // result fields
    always_comb begin
        o_result              = '0;
        o_result.frame_length = w_count_inc;
        if (w_match) begin
            o_result.frame_status = ahfp_pkg::STATUS_OK;
            o_result.command_word = {w_dec[0][3:0], 12'h000} | {w_dec[1], 8'h00}
                                  | {4'h0, w_dec[2], 4'h0} | {8'h00, w_dec[3]};
            o_result.data_byte_0  = {w_dec[6][3:0], 4'h0} | w_dec[7];
            o_result.data_byte_1  = {w_dec[8][3:0], 4'h0} | w_dec[9];
            o_result.data_byte_2  = {w_dec[10][3:0], 4'h0} | w_dec[11];
            o_result.data_byte_3  = {w_dec[12][3:0], 4'h0} | w_dec[13];
        end else begin
            o_result.frame_status = ahfp_pkg::STATUS_CHK_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_byte_count  <= 8'd0;
            r_running_sum <= 8'd0;
            for (int i = 0; i < ahfp_pkg::STORE_DEPTH; i++) begin
                r_store[i] <= 8'd0;
            end
        end else begin
            r_in_frame    <= n_in_frame;
            r_byte_count  <= n_byte_count;
            r_running_sum <= n_running_sum;
            r_store       <= n_store;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_byte_count == 8'd0 && r_running_sum == 8'd0))
        else $error("count or sum nonzero outside a frame");

    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_fire |=> !r_in_frame)
        else $error("frame still open after end byte");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_frame && $past(r_in_frame) && $past(r_byte_count) == ahfp_pkg::COUNT_MAX)
        |-> r_byte_count == ahfp_pkg::COUNT_MAX)
        else $error("byte count wrapped");

endmodule

// File: hdl/ascii_hex_frame_parser.sv
// Top level of the ASCII-hex serial frame parser with 8-bit sum checksum.
// Usage:
//   Feed received bytes on the rx channel (i_rx_valid / o_rx_ready / i_rx_byte),
//   one beat per byte. Outside a frame only the start byte matters; it opens
//   a frame. Inside a frame every byte but the end byte is payload. Each end
//   byte inside a frame yields one beat on the result channel
//   (o_res_valid / i_res_ready) with status, length, command word and four
//   data bytes; status 1 means checksum mismatch and the data fields are zero.
//   Start and end delimiters are APB registers at 0x0 and 0x4; write them
//   only while the parser is idle.
// Throughput and timing:
//   One byte per cycle when not stalled; an end byte's result sits in the output
//   register in the cycle after the byte is taken. Hex decode of the store, checksum
//   compare and store update all fit between the state and output registers.
// Reset:
//   Synchronous, active low. Leaves the parser outside a frame, clears the
//   store, restores delimiters 0x5B and 0x5D, and empties the output register.
// Stall:
//   A held result blocks further bytes only while i_res_ready is low; when the
//   result is taken, a new byte is accepted in the same cycle.
module ascii_hex_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // received byte channel
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_frame_status,
    output logic [7:0]  o_frame_length,
    output logic [15:0] o_command_word,
    output logic [7:0]  o_data_byte_0,
    output logic [7:0]  o_data_byte_1,
    output logic [7:0]  o_data_byte_2,
    output logic [7:0]  o_data_byte_3
);

    ahfp_pkg::t_cfg    w_cfg;
    ahfp_pkg::t_result w_result;
    logic              w_res_fire;
    logic              w_rx_beat;

    logic              r_res_valid;
    logic              n_res_valid;
    ahfp_pkg::t_result r_result;

    ahfp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Take a byte whenever the output register is empty or being drained.
    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign w_rx_beat  = i_rx_valid && o_rx_ready;

    ahfp_frame_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_beat     (w_rx_beat),
        .i_rx_byte  (i_rx_byte),
        .o_res_fire (w_res_fire),
        .o_result   (w_result)
    );

    // Load on a frame close; drop the valid flag once the beat is taken.
    always_comb begin
        n_res_valid = r_res_valid;
        if (w_res_fire) begin
            n_res_valid = 1'b1;
        end else if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
        end
    end

    // Payload holds while the receiver stalls; it only loads on a close.
    always_ff @(posedge i_clk) begin
        if (w_res_fire) begin
            r_result <= w_result;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_frame_status = r_result.frame_status;
    assign o_frame_length = r_result.frame_length;
    assign o_command_word = r_result.command_word;
    assign o_data_byte_0  = r_result.data_byte_0;
    assign o_data_byte_1  = r_result.data_byte_1;
    assign o_data_byte_2  = r_result.data_byte_2;
    assign o_data_byte_3  = r_result.data_byte_3;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_fire |-> (!r_res_valid || i_res_ready))
        else $error("result overwritten before it was taken");

    a_fire_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_fire |=> o_res_valid)
        else $error("frame close did not raise result valid");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

endmodule

// File: tb/ahfp_frame_monitor.sv
// Watches the parser channels, predicts every frame result and compares it on arrival.
module ahfp_frame_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_frame_status,
    input  logic [7:0]  i_frame_length,
    input  logic [15:0] i_command_word,
    input  logic [7:0]  i_data_byte_0,
    input  logic [7:0]  i_data_byte_1,
    input  logic [7:0]  i_data_byte_2,
    input  logic [7:0]  i_data_byte_3,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_frame_count,
    output int          o_error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    logic [7:0]        start_cfg;
    logic [7:0]        end_cfg;
    logic              in_frame;
    logic [7:0]        byte_count;
    logic [7:0]        running_sum;
    logic [7:0]        store_img [ahfp_pkg::STORE_DEPTH];
    ahfp_pkg::t_result frames_due [$];
    int                fail_total;
    int                frames_seen;
    int                errors_seen;

    function automatic logic [7:0] ascii_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = c - ahfp_pkg::ASCII_ZERO;
        if (v > 8'd9) begin
            v = v - ahfp_pkg::ALPHA_GAP;
        end
        return v;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            fail_total++;
            if (fail_total <= MAX_REPORTS) begin
                $display("frame %0d: %s expected 0x%0h, got 0x%0h",
                         frames_seen, field, want, got);
            end
        end
    endfunction

    task automatic parse_byte(input logic [7:0] c);
        ahfp_pkg::t_result r;
        logic [7:0]        rx_chk;
        if (!in_frame) begin
            if (c == start_cfg) begin
                in_frame    = 1'b1;
                byte_count  = '0;
                running_sum = '0;
            end
            return;
        end
        if (byte_count != ahfp_pkg::COUNT_MAX) begin
            byte_count++;
        end
        if (c == end_cfg) begin
            rx_chk = (ascii_nibble(store_img[ahfp_pkg::CHK_HI_POS]) << 4) |
                     ascii_nibble(store_img[ahfp_pkg::CHK_LO_POS]);
            r = '0;
            r.frame_length = byte_count;
            if (rx_chk == running_sum) begin
                for (int i = 0; i < ahfp_pkg::STORE_DEPTH; i++) begin
                    store_img[i] = ascii_nibble(store_img[i]);
                end
                r.frame_status = ahfp_pkg::STATUS_OK;
                r.command_word = ({8'h00, store_img[0]} << 12) | ({8'h00, store_img[1]} << 8) |
                                 ({8'h00, store_img[2]} << 4) | {8'h00, store_img[3]};
                r.data_byte_0  = (store_img[6] << 4) | store_img[7];
                r.data_byte_1  = (store_img[8] << 4) | store_img[9];
                r.data_byte_2  = (store_img[10] << 4) | store_img[11];
                r.data_byte_3  = (store_img[12] << 4) | store_img[13];
            end else begin
                r.frame_status = ahfp_pkg::STATUS_CHK_ERR;
            end
            frames_due.push_back(r);
            in_frame    = 1'b0;
            byte_count  = '0;
            running_sum = '0;
        end else begin
            if (byte_count >= 1 && byte_count <= ahfp_pkg::STORE_DEPTH) begin
                store_img[byte_count - 1] = c;
            end
            if (byte_count <= ahfp_pkg::SUM_SPAN) begin
                running_sum = running_sum + c;
            end
        end
    endtask

    task automatic check_result();
        ahfp_pkg::t_result want;
        frames_seen++;
        if (frames_due.size() == 0) begin
            fail_total++;
            if (fail_total <= MAX_REPORTS) begin
                $display("frame %0d: result beat with no frame pending", frames_seen);
            end
            return;
        end
        want = frames_due.pop_front();
        if (want.frame_status == ahfp_pkg::STATUS_CHK_ERR) begin
            errors_seen++;
        end
        check_field("frame_status", want.frame_status, i_frame_status);
        check_field("frame_length", want.frame_length, i_frame_length);
        check_field("command_word", want.command_word, i_command_word);
        check_field("data_byte_0", want.data_byte_0, i_data_byte_0);
        check_field("data_byte_1", want.data_byte_1, i_data_byte_1);
        check_field("data_byte_2", want.data_byte_2, i_data_byte_2);
        check_field("data_byte_3", want.data_byte_3, i_data_byte_3);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_cfg   = ahfp_pkg::START_BYTE_RST;
            end_cfg     = ahfp_pkg::END_BYTE_RST;
            in_frame    = 1'b0;
            byte_count  = '0;
            running_sum = '0;
            for (int i = 0; i < ahfp_pkg::STORE_DEPTH; i++) begin
                store_img[i] = '0;
            end
            frames_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == ahfp_pkg::REG_START_BYTE) begin
                    start_cfg = i_pwdata[7:0];
                end else begin
                    end_cfg = i_pwdata[7:0];
                end
            end
            // a result beat always stems from an earlier byte, so retire it first
            if (i_res_valid && i_res_ready) begin
                check_result();
            end
            if (i_rx_valid && i_rx_ready) begin
                parse_byte(i_rx_byte);
            end
        end
        o_pending     <= frames_due.size();
        o_fail_count  <= fail_total;
        o_frame_count <= frames_seen;
        o_error_count <= errors_seen;
    end

endmodule

// File: tb/ascii_hex_frame_parser_test.sv
// Stimulus and verdict for the ASCII-hex frame parser, with the frame monitor beside it.
module ascii_hex_frame_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int PHASE_BYTES = 135;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_QUIET = 8;

    // kinds of byte sequences the random part mixes
    typedef enum int {
        SEQ_GOOD,
        SEQ_BAD_SUM,
        SEQ_SHORT,
        SEQ_LONG,
        SEQ_NOISE
    } t_seq;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_rx_valid  = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte   = '0;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    logic        o_frame_status;
    logic [7:0]  o_frame_length;
    logic [15:0] o_command_word;
    logic [7:0]  o_data_byte_0;
    logic [7:0]  o_data_byte_1;
    logic [7:0]  o_data_byte_2;
    logic [7:0]  o_data_byte_3;

    int fail_count;
    int pending;
    int frame_count;
    int error_count;

    // shared between the sender and the result sink
    bit idle_on     = 1'b0;
    bit calm        = 1'b0;
    int hold_ticket = 0;
    int bytes_sent  = 0;
    int cycles      = 0;

    // delimiters as last written, so well-formed frames can be built
    logic [7:0] cur_start = ahfp_pkg::START_BYTE_RST;
    logic [7:0] cur_end   = ahfp_pkg::END_BYTE_RST;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ascii_hex_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_frame_status (o_frame_status),
        .o_frame_length (o_frame_length),
        .o_command_word (o_command_word),
        .o_data_byte_0  (o_data_byte_0),
        .o_data_byte_1  (o_data_byte_1),
        .o_data_byte_2  (o_data_byte_2),
        .o_data_byte_3  (o_data_byte_3)
    );

    ahfp_frame_monitor frame_mon (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .i_rx_valid     (i_rx_valid),
        .i_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .i_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .i_frame_status (o_frame_status),
        .i_frame_length (o_frame_length),
        .i_command_word (o_command_word),
        .i_data_byte_0  (o_data_byte_0),
        .i_data_byte_1  (o_data_byte_1),
        .i_data_byte_2  (o_data_byte_2),
        .i_data_byte_3  (o_data_byte_3),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_frame_count  (frame_count),
        .o_error_count  (error_count)
    );

    // Result sink: ready drops for random bursts while idling is on, and for one
    // long stretch each time the stimulus bumps hold_ticket.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_ticket != hold_seen) begin
                hold_seen = hold_ticket;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_res_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_res_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d frames still pending", cycles, pending);
        $display("ascii_hex_frame_parser_test: FAIL");
        $finish;
    end

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + n) : (8'h41 + n - 8'd10);
    endfunction

    // Mostly upper-case hex, some lower case and some arbitrary bytes; never
    // the end byte, so the frame stays open.
    function automatic logic [7:0] payload_char();
        logic [7:0] c;
        do begin
            case ($urandom_range(0, 9))
                0: begin
                    c = 8'($urandom_range(0, 255));
                end
                1: begin
                    c = 8'($urandom_range(8'h61, 8'h66));
                end
                default: begin
                    c = hex_ascii(4'($urandom_range(0, 15)));
                end
            endcase
        end while (c == cur_end);
        return c;
    endfunction

    // Offer one beat; hold valid and payload until accepted. A random gap may
    // precede it, with valid low.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Drop valid and wait until no result is pending.
    task automatic wait_drained();
        int quiet;
        quiet = 0;
        i_rx_valid <= 1'b0;
        while (quiet < DRAIN_QUIET) begin
            @(posedge i_clk);
            if (pending == 0) begin
                quiet++;
            end else begin
                quiet = 0;
            end
        end
    endtask

    // Setup cycle, then access cycle; the extra edge at the end keeps two
    // back-to-back writes from touching psel twice in one step.
    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_delims(input logic [7:0] s, input logic [7:0] e, input bit junk);
        logic [23:0] upper;
        upper = junk ? 24'($urandom) : '0;
        apb_write(ahfp_pkg::REG_START_BYTE, {upper, s});
        upper = junk ? 24'($urandom) : '0;
        apb_write(ahfp_pkg::REG_END_BYTE, {upper, e});
        cur_start = s;
        cur_end   = e;
    endtask

    // Full frame: start byte, 14 payload chars, two hex checksum chars (optionally
    // corrupted), optional trailing bytes that overflow the store, then the end byte.
    task automatic send_good_frame(input int extra, input bit corrupt);
        logic [7:0] body [16];
        logic [7:0] chk_sum;
        chk_sum = '0;
        for (int i = 0; i < ahfp_pkg::SUM_SPAN; i++) begin
            body[i] = payload_char();
            chk_sum = chk_sum + body[i];
        end
        if (corrupt) begin
            chk_sum = chk_sum ^ (8'd1 << $urandom_range(0, 7));
        end
        body[ahfp_pkg::CHK_HI_POS] = hex_ascii(chk_sum[7:4]);
        body[ahfp_pkg::CHK_LO_POS] = hex_ascii(chk_sum[3:0]);
        send_byte(cur_start);
        for (int i = 0; i < ahfp_pkg::STORE_DEPTH; i++) begin
            send_byte(body[i]);
        end
        repeat (extra) send_byte(payload_char());
        send_byte(cur_end);
    endtask

    // Short frame: leaves stale store entries in the checksum and outputs.
    task automatic send_short_frame();
        int n;
        n = $urandom_range(0, ahfp_pkg::STORE_DEPTH - 1);
        send_byte(cur_start);
        repeat (n) send_byte(payload_char());
        send_byte(cur_end);
    endtask

    // Bytes between frames; mostly not the start byte, so they are ignored.
    task automatic send_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, 8);
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == cur_start && $urandom_range(0, 3) != 0) begin
                b = ~b;
            end
            send_byte(b);
        end
    endtask

    task automatic run_phase(input int quota);
        int   first;
        t_seq seq;
        int   pick;
        first = bytes_sent;
        while (bytes_sent - first < quota) begin
            // stretches without idling are mixed at random with idling ones
            idle_on = !calm && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                seq = SEQ_GOOD;
            end else if (pick < 70) begin
                seq = SEQ_BAD_SUM;
            end else if (pick < 82) begin
                seq = SEQ_SHORT;
            end else if (pick < 92) begin
                seq = SEQ_LONG;
            end else begin
                seq = SEQ_NOISE;
            end
            case (seq)
                SEQ_GOOD: begin
                    send_good_frame(0, 1'b0);
                end
                SEQ_BAD_SUM: begin
                    send_good_frame(0, 1'b1);
                end
                SEQ_SHORT: begin
                    send_short_frame();
                end
                SEQ_LONG: begin
                    send_good_frame($urandom_range(1, 24), $urandom_range(0, 3) == 0);
                end
                default: begin
                    send_noise();
                end
            endcase
        end
    endtask

    initial begin : stimulus
        logic [7:0] s;
        logic [7:0] e;

        // hold reset, then release it for good
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes outside a frame are ignored.
        send_byte(8'h00);
        send_byte(8'hFF);
        // Short frame against the cleared store: 12 x '4', a start byte as
        // data and 0x0E sum to 0xD9, which is what the zero entries at the
        // checksum positions decode to, so the frame matches on stale data.
        send_byte(ahfp_pkg::START_BYTE_RST);
        repeat (12) send_byte(8'h34);
        send_byte(ahfp_pkg::START_BYTE_RST);
        send_byte(8'h0E);
        send_byte(ahfp_pkg::END_BYTE_RST);
        // Empty frame.
        send_byte(ahfp_pkg::START_BYTE_RST);
        send_byte(ahfp_pkg::END_BYTE_RST);

        run_phase(PHASE_BYTES);

        // Lowest start, highest end. Hold the result side off for a long
        // stretch while frames keep coming, so the parser stalls its input.
        wait_drained();
        set_delims(8'h00, 8'hFF, 1'b0);
        idle_on = 1'b0;
        hold_ticket++;
        repeat (6) send_short_frame();
        // pause the sender until every frame has been answered
        wait_drained();
        run_phase(PHASE_BYTES);

        // Highest start, lowest end, plus one frame long enough to saturate
        // the length count.
        wait_drained();
        set_delims(8'hFF, 8'h00, 1'b0);
        idle_on = 1'b0;
        send_good_frame(290, 1'b0);
        run_phase(PHASE_BYTES);

        // Same byte opens and closes.
        wait_drained();
        set_delims(8'h7E, 8'h7E, 1'b0);
        run_phase(PHASE_BYTES);

        // Random delimiters, sometimes equal, with junk in the upper data bits.
        wait_drained();
        s = 8'($urandom_range(0, 255));
        e = ($urandom_range(0, 2) == 0) ? s : 8'($urandom_range(0, 255));
        set_delims(s, e, 1'b1);
        run_phase(PHASE_BYTES);

        // Back to the reset delimiters, no idling on either side.
        wait_drained();
        set_delims(ahfp_pkg::START_BYTE_RST, ahfp_pkg::END_BYTE_RST, 1'b0);
        calm    = 1'b1;
        idle_on = 1'b0;
        run_phase(PHASE_BYTES);

        wait_drained();

        $display("sent %0d bytes under six delimiter settings in %0d cycles", bytes_sent, cycles);
        $display("checked %0d frame results, %0d of them checksum errors",
                 frame_count, error_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ascii_hex_frame_parser_test: PASS");
        end else begin
            $display("ascii_hex_frame_parser_test: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/ahfp_pkg.sv
hdl/ahfp_apb_regs.sv
hdl/ahfp_frame_core.sv
hdl/ascii_hex_frame_parser.sv
tb/ahfp_frame_monitor.sv
tb/ascii_hex_frame_parser_test.sv
